// ===== rtl/mpi_pkg.sv =====
package mpi_pkg;

    typedef struct packed {
        logic clear;
        logic advance;
    } color_ctl_t;

    localparam logic [7:0] COLOR_MOD  = 8'd255;
    localparam logic [7:0] RED_STEP   = 8'd5;
    localparam logic [7:0] GREEN_STEP = 8'd20;
    localparam logic [7:0] BLUE_STEP  = 8'd10;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_STEP   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_STEP   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER = 3'd4;

    function automatic logic [7:0] mod_add(input logic [7:0] acc, input logic [7:0] inc);
        logic [8:0] sum;
        sum = {1'b0, acc} + {1'b0, inc};
        if (sum >= {1'b0, COLOR_MOD})
        begin
            sum = sum - {1'b0, COLOR_MOD};
        end
        return sum[7:0];
    endfunction

endpackage

// ===== rtl/mpi_color.sv =====
module mpi_color (
    input  logic               clk,
    input  logic               rst_n,
    input  mpi_pkg::color_ctl_t ctl,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    always_comb
    begin
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (ctl.clear)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
        else if (ctl.advance)
        begin
            red_next   = mpi_pkg::mod_add(red_reg, mpi_pkg::RED_STEP);
            green_next = mpi_pkg::mod_add(green_reg, mpi_pkg::GREEN_STEP);
            blue_next  = mpi_pkg::mod_add(blue_reg, mpi_pkg::BLUE_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== rtl/mandelbrot_pixel_iterator.sv =====
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | column, row
// output   | out_valid / out_stall| out_column, out_row, iterations, red, green, blue
// config   | cfg_we               | cfg_index, cfg_data
//
// States: CR, CI, CZ, then MRR, MII, MRI, UPD per iteration; exit from MRR or MRI.
// A single shared multiplier forms zr*zr, zi*zi and zr*zi in turn, one per cycle.
// Reset loads the default view and clears all control state.
// in_stall is high while an item is in work; a stalled result holds in the
// output register and the next item may be accepted meanwhile.
module mandelbrot_pixel_iterator #(
    parameter int FRAC_BITS = 26,
    parameter int ITER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [10:0]                         column,
    input  logic [10:0]                         row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [10:0]                         out_column,
    output logic [10:0]                         out_row,
    output logic [15:0]                         iterations,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    input  logic                                cfg_we,
    input  logic [mpi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mpi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int OW  = FRAC_BITS + 3;
    localparam int PW  = 2 * OW;
    localparam int ZW  = ((FRAC_BITS + 7 > 32) ? FRAC_BITS + 7 : 32) + 1;
    localparam int XW  = (PW + 1 > ZW) ? PW + 1 : ZW;

    localparam logic signed [ZW-1:0] FOUR  = ZW'(4) <<< FRAC_BITS;
    localparam logic signed [XW-1:0] LIMIT = XW'(1) <<< (2 * FRAC_BITS + 4);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_CI   = 4'd2;
    localparam logic [3:0] S_CZ   = 4'd3;
    localparam logic [3:0] S_MRR  = 4'd4;
    localparam logic [3:0] S_MII  = 4'd5;
    localparam logic [3:0] S_MRI  = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
        if (v > 45'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -45'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    logic [3:0]               state_reg;
    logic [3:0]               state_next;

    logic signed [31:0]       x_origin_reg;
    logic signed [31:0]       y_origin_reg;
    logic signed [31:0]       x_step_reg;
    logic signed [31:0]       y_step_reg;
    logic [15:0]              max_iter_reg;

    logic [10:0]              col_reg;
    logic [10:0]              row_reg;
    logic signed [43:0]       map_reg;
    logic signed [31:0]       cr_reg;
    logic signed [31:0]       ci_reg;
    logic signed [ZW-1:0]     zr_reg;
    logic signed [ZW-1:0]     zi_reg;
    logic signed [PW-1:0]     rr_reg;
    logic signed [PW-1:0]     ii_reg;
    logic signed [PW-1:0]     ri_reg;
    logic [ITER_BITS-1:0]     n_reg;

    logic                     out_valid_reg;
    logic [10:0]              out_column_reg;
    logic [10:0]              out_row_reg;
    logic [15:0]              iterations_reg;
    logic [7:0]               red_reg;
    logic [7:0]               green_reg;
    logic [7:0]               blue_reg;

    logic signed [11:0]       map_idx;
    logic signed [31:0]       map_step;
    logic signed [43:0]       map_prod;
    logic signed [44:0]       map_sum;
    logic signed [31:0]       map_origin;
    logic signed [OW-1:0]     mul_a;
    logic signed [OW-1:0]     mul_b;
    logic signed [PW-1:0]     mul_prod;
    logic signed [XW-1:0]     sq_sum;
    logic signed [XW-1:0]     diff_x;
    logic signed [XW-1:0]     twori_x;
    logic [ITER_BITS-1:0]     lim;
    logic                     big;
    logic                     escaped;
    logic                     out_load;
    logic                     accept;
    mpi_pkg::color_ctl_t      color_ctl;
    logic [7:0]               color_red;
    logic [7:0]               color_green;
    logic [7:0]               color_blue;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign lim      = ITER_BITS'(max_iter_reg);

    assign map_idx    = (state_reg == S_CR) ? $signed({1'b0, col_reg}) : $signed({1'b0, row_reg});
    assign map_step   = (state_reg == S_CR) ? x_step_reg : y_step_reg;
    assign map_prod   = 44'(map_idx) * 44'(map_step);
    assign map_origin = (state_reg == S_CI) ? x_origin_reg : y_origin_reg;
    assign map_sum    = 45'(map_origin) + 45'(map_reg);

    always_comb
    begin
        mul_a = zr_reg[OW-1:0];
        mul_b = zr_reg[OW-1:0];
        case (state_reg)
            S_MII:
            begin
                mul_a = zi_reg[OW-1:0];
                mul_b = zi_reg[OW-1:0];
            end
            S_MRI:
            begin
                mul_b = zi_reg[OW-1:0];
            end
            default:
            begin
                mul_b = zr_reg[OW-1:0];
            end
        endcase
    end

    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    assign big     = (zr_reg >= FOUR) || (zr_reg <= -FOUR) ||
                     (zi_reg >= FOUR) || (zi_reg <= -FOUR);
    assign sq_sum  = XW'(rr_reg) + XW'(ii_reg);
    assign escaped = (sq_sum >= LIMIT);
    assign diff_x  = XW'(rr_reg) - XW'(ii_reg);
    assign twori_x = XW'(ri_reg) <<< 1;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CR;
                end
            end
            S_CR:   state_next = S_CI;
            S_CI:   state_next = S_CZ;
            S_CZ:   state_next = S_MRR;
            S_MRR:
            begin
                if ((n_reg >= lim) || big)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MII;
                end
            end
            S_MII:  state_next = S_MRI;
            S_MRI:  state_next = escaped ? S_DONE : S_UPD;
            S_UPD:  state_next = S_MRR;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign color_ctl.clear   = (state_reg == S_CZ);
    assign color_ctl.advance = (state_reg == S_UPD);

    mpi_color u_color (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (color_ctl),
        .red   (color_red),
        .green (color_green),
        .blue  (color_blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            x_origin_reg  <= -32'sd100663296;
            y_origin_reg  <= -32'sd67108864;
            x_step_reg    <= 32'sd209715;
            y_step_reg    <= 32'sd279620;
            max_iter_reg  <= 16'd500;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    mpi_pkg::CFG_X_ORIGIN: x_origin_reg <= $signed(cfg_data);
                    mpi_pkg::CFG_Y_ORIGIN: y_origin_reg <= $signed(cfg_data);
                    mpi_pkg::CFG_X_STEP:   x_step_reg   <= $signed(cfg_data);
                    mpi_pkg::CFG_Y_STEP:   y_step_reg   <= $signed(cfg_data);
                    mpi_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[15:0];
                    default:               max_iter_reg <= max_iter_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        case (state_reg)
            S_CR:
            begin
                map_reg <= map_prod;
            end
            S_CI:
            begin
                cr_reg  <= sat32(map_sum);
                map_reg <= map_prod;
            end
            S_CZ:
            begin
                ci_reg <= sat32(map_sum);
                zr_reg <= '0;
                zi_reg <= '0;
                n_reg  <= '0;
            end
            S_MRR:  rr_reg <= mul_prod;
            S_MII:  ii_reg <= mul_prod;
            S_MRI:  ri_reg <= mul_prod;
            S_UPD:
            begin
                zr_reg <= ZW'(diff_x >>> FRAC_BITS) + ZW'(cr_reg);
                zi_reg <= ZW'(twori_x >>> FRAC_BITS) + ZW'(ci_reg);
                n_reg  <= n_reg + ITER_BITS'(1);
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
        if (out_load)
        begin
            out_column_reg <= col_reg;
            out_row_reg    <= row_reg;
            iterations_reg <= 16'(n_reg);
            red_reg        <= color_red;
            green_reg      <= color_green;
            blue_reg       <= color_blue;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_column = out_column_reg;
    assign out_row    = out_row_reg;
    assign iterations = iterations_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

endmodule
